// ===== src/tbo_pkg.sv =====
// shared widths, register indexes, stage enables and multiply helpers
package tbo_pkg;

    localparam int CW = 16;
    localparam int AW = 3;
    localparam int VW = 18;
    localparam int EW = 19;
    localparam int WW = 17;
    localparam int PW = 40;
    localparam int NW = 39;
    localparam int NS = 19;
    localparam int SW = 60;

    localparam logic [AW-1:0] REG_MIN_X = 3'd0;
    localparam logic [AW-1:0] REG_MIN_Y = 3'd1;
    localparam logic [AW-1:0] REG_MIN_Z = 3'd2;
    localparam logic [AW-1:0] REG_MAX_X = 3'd3;
    localparam logic [AW-1:0] REG_MAX_Y = 3'd4;
    localparam logic [AW-1:0] REG_MAX_Z = 3'd5;

    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
        logic s4;
        logic s5;
    } stage_en_t;

    function automatic logic signed [EW+VW-1:0] mul_ev(input logic signed [EW-1:0] a,
                                                       input logic signed [VW-1:0] b);
        logic signed [EW+VW-1:0] r;
        r = a * b;
        return r;
    endfunction

    function automatic logic signed [2*EW-1:0] mul_ee(input logic signed [EW-1:0] a,
                                                      input logic signed [EW-1:0] b);
        logic signed [2*EW-1:0] r;
        r = a * b;
        return r;
    endfunction

    function automatic logic signed [WW+EW:0] mul_w20(input logic signed [WW-1:0] a,
                                                      input logic signed [EW:0] b);
        logic signed [WW+EW:0] r;
        r = a * b;
        return r;
    endfunction

    function automatic logic signed [VW+EW:0] mul_v20(input logic signed [VW-1:0] a,
                                                      input logic signed [EW:0] b);
        logic signed [VW+EW:0] r;
        r = a * b;
        return r;
    endfunction

    function automatic logic signed [EW:0] abs_e(input logic signed [EW-1:0] a);
        logic signed [EW:0] x;
        x = {a[EW-1], a};
        return x[EW] ? -x : x;
    endfunction

endpackage

// ===== src/triangle_box_overlap_test_core.sv =====
// top level: box registers, pipeline control and result channel
//
// Triangle against axis-aligned box overlap test, separating axis method.
// Input channel s_valid/s_ready carries one triangle per transfer as three
// signed 16-bit vertices (s_a_x .. s_c_z). Result channel m_valid/m_ready
// carries one bit per triangle, m_overlaps, high when no axis separates.
// Configuration channel cfg_valid/cfg_ready writes the six box corner
// registers by index (min x,y,z then max x,y,z); other indexes are ignored.
// Write the box only while no triangle is in flight; cfg_ready is always high.
// Five register stages: vertex offsets, axis products, edge axis compares
// with the normal, split normal products, final normal compare. m_valid is
// the fifth stage's valid bit; one triangle per cycle while no stage stalls.
// Each stage holds its item while the next cannot take it, so a stalled receiver
// backs up the pipe stage by stage and s_ready falls only when all are full.
// Reset clears the stage valid bits and sets all box registers to zero.
module triangle_box_overlap_test_core import tbo_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic signed [CW-1:0]  s_a_x,
    input  logic signed [CW-1:0]  s_a_y,
    input  logic signed [CW-1:0]  s_a_z,
    input  logic signed [CW-1:0]  s_b_x,
    input  logic signed [CW-1:0]  s_b_y,
    input  logic signed [CW-1:0]  s_b_z,
    input  logic signed [CW-1:0]  s_c_x,
    input  logic signed [CW-1:0]  s_c_y,
    input  logic signed [CW-1:0]  s_c_z,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic                  m_overlaps,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [AW-1:0]         cfg_addr,
    input  logic [CW-1:0]         cfg_data
);

    logic signed [CW-1:0] box_min_reg [3];
    logic signed [CW-1:0] box_max_reg [3];
    logic signed [CW-1:0] vin [3][3];
    logic [5:1]           valid_reg;
    logic [5:1]           rdy;
    stage_en_t            en;
    logic signed [VW-1:0] v_reg   [3][3];
    logic signed [EW-1:0] e_reg   [3][3];
    logic signed [EW-1:0] e13_reg [3];
    logic signed [WW-1:0] w_reg   [3];
    logic                 sep_axis;
    logic                 sep_norm;
    logic                 sep4_reg;
    logic                 sep5_reg;

    assign vin[0] = '{s_a_x, s_a_y, s_a_z};
    assign vin[1] = '{s_b_x, s_b_y, s_b_z};
    assign vin[2] = '{s_c_x, s_c_y, s_c_z};

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int j = 0; j < 3; j++) begin
                box_min_reg[j] <= '0;
                box_max_reg[j] <= '0;
            end
        end else if (cfg_valid) begin
            unique case (cfg_addr)
                REG_MIN_X: box_min_reg[0] <= cfg_data;
                REG_MIN_Y: box_min_reg[1] <= cfg_data;
                REG_MIN_Z: box_min_reg[2] <= cfg_data;
                REG_MAX_X: box_max_reg[0] <= cfg_data;
                REG_MAX_Y: box_max_reg[1] <= cfg_data;
                REG_MAX_Z: box_max_reg[2] <= cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        rdy[5] = !valid_reg[5] || m_ready;
        for (int k = 4; k >= 1; k--) begin
            rdy[k] = !valid_reg[k] || rdy[k + 1];
        end
    end

    assign en = '{s1: rdy[1], s2: rdy[2], s3: rdy[3], s4: rdy[4], s5: rdy[5]};
    assign s_ready = rdy[1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            if (rdy[1]) valid_reg[1] <= s_valid;
            for (int k = 2; k <= 5; k++) begin
                if (rdy[k]) valid_reg[k] <= valid_reg[k - 1];
            end
        end
    end

    tbo_prep u_prep (
        .aclk    (aclk),
        .en      (en),
        .vin     (vin),
        .box_min (box_min_reg),
        .box_max (box_max_reg),
        .v_reg   (v_reg),
        .e_reg   (e_reg),
        .e13_reg (e13_reg),
        .w_reg   (w_reg)
    );

    tbo_axis u_axis (
        .aclk    (aclk),
        .en      (en),
        .v_reg   (v_reg),
        .e_reg   (e_reg),
        .w_reg   (w_reg),
        .sep_reg (sep_axis)
    );

    tbo_normal u_normal (
        .aclk    (aclk),
        .en      (en),
        .v0      (v_reg[0]),
        .e0      (e_reg[0]),
        .e13     (e13_reg),
        .w_in    (w_reg),
        .sep_reg (sep_norm)
    );

    always_ff @(posedge aclk) begin
        if (rdy[4]) sep4_reg <= sep_axis;
        if (rdy[5]) sep5_reg <= sep4_reg;
    end

    assign m_valid    = valid_reg[5];
    assign m_overlaps = !(sep5_reg | sep_norm);

    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");
    a_hold_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_overlaps)))
        else $error("stalled result lost or changed");
    a_stage_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (valid_reg[1] && !rdy[2]) |=> valid_reg[1])
        else $error("stage one item dropped under stall");
    a_full_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        ((&valid_reg) && !m_ready) |-> !s_ready)
        else $error("input taken with full pipeline");

endmodule

// ===== src/tbo_prep.sv =====
// stage one: doubled vertex offsets, edges and box widths
module tbo_prep import tbo_pkg::*; (
    input  logic                  aclk,
    input  stage_en_t             en,
    input  logic signed [CW-1:0]  vin     [3][3],
    input  logic signed [CW-1:0]  box_min [3],
    input  logic signed [CW-1:0]  box_max [3],
    output logic signed [VW-1:0]  v_reg   [3][3],
    output logic signed [EW-1:0]  e_reg   [3][3],
    output logic signed [EW-1:0]  e13_reg [3],
    output logic signed [WW-1:0]  w_reg   [3]
);

    logic signed [VW-1:0] c2     [3];
    logic signed [VW-1:0] v_next [3][3];

    always_comb begin
        for (int j = 0; j < 3; j++) begin
            c2[j] = VW'(box_min[j]) + VW'(box_max[j]);
            for (int i = 0; i < 3; i++) begin
                v_next[i][j] = (VW'(vin[i][j]) <<< 1) - c2[j];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en.s1) begin
            for (int j = 0; j < 3; j++) begin
                w_reg[j]   <= WW'(box_max[j]) - WW'(box_min[j]);
                e13_reg[j] <= EW'(v_next[2][j]) - EW'(v_next[0][j]);
                for (int i = 0; i < 3; i++) begin
                    v_reg[i][j] <= v_next[i][j];
                    e_reg[i][j] <= EW'(v_next[(i == 2) ? 0 : i + 1][j]) - EW'(v_next[i][j]);
                end
            end
        end
    end

endmodule

// ===== src/tbo_axis.sv =====
// stages two and three: edge cross axes and box axes
module tbo_axis import tbo_pkg::*; (
    input  logic                  aclk,
    input  stage_en_t             en,
    input  logic signed [VW-1:0]  v_reg [3][3],
    input  logic signed [EW-1:0]  e_reg [3][3],
    input  logic signed [WW-1:0]  w_reg [3],
    output logic                  sep_reg
);

    logic signed [PW-1:0] p_reg   [3][3][3];
    logic signed [PW-1:0] r_reg   [3][3];
    logic                 box_sep_reg;
    logic                 box_sep_next;
    logic                 edge_sep_next;

    always_ff @(posedge aclk) begin
        if (en.s2) begin
            for (int i = 0; i < 3; i++) begin
                for (int k = 0; k < 3; k++) begin
                    r_reg[i][k] <=
                        PW'(mul_w20(w_reg[(k + 1) % 3], abs_e(e_reg[i][(k + 2) % 3]))) +
                        PW'(mul_w20(w_reg[(k + 2) % 3], abs_e(e_reg[i][(k + 1) % 3])));
                    for (int j = 0; j < 3; j++) begin
                        p_reg[i][k][j] <=
                            PW'(mul_ev(e_reg[i][(k + 1) % 3], v_reg[j][(k + 2) % 3])) -
                            PW'(mul_ev(e_reg[i][(k + 2) % 3], v_reg[j][(k + 1) % 3]));
                    end
                end
            end
            box_sep_reg <= box_sep_next;
        end
    end

    always_comb begin
        logic signed [VW:0] bhi, blo, bm;
        box_sep_next = 1'b0;
        for (int k = 0; k < 3; k++) begin
            bhi = (VW+1)'(v_reg[0][k]);
            blo = bhi;
            for (int j = 1; j < 3; j++) begin
                if ((VW+1)'(v_reg[j][k]) > bhi) bhi = (VW+1)'(v_reg[j][k]);
                if ((VW+1)'(v_reg[j][k]) < blo) blo = (VW+1)'(v_reg[j][k]);
            end
            bm = (-bhi > blo) ? -bhi : blo;
            if (bm > (VW+1)'(w_reg[k])) box_sep_next = 1'b1;
        end
    end

    always_comb begin
        logic signed [PW-1:0] hi, lo, m;
        edge_sep_next = 1'b0;
        for (int i = 0; i < 3; i++) begin
            for (int k = 0; k < 3; k++) begin
                hi = p_reg[i][k][0];
                lo = hi;
                for (int j = 1; j < 3; j++) begin
                    if (p_reg[i][k][j] > hi) hi = p_reg[i][k][j];
                    if (p_reg[i][k][j] < lo) lo = p_reg[i][k][j];
                end
                m = (-hi > lo) ? -hi : lo;
                if (m > r_reg[i][k]) edge_sep_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en.s3) begin
            sep_reg <= edge_sep_next | box_sep_reg;
        end
    end

endmodule

// ===== src/tbo_normal.sv =====
// stages two to five: triangle normal axis with split wide products
module tbo_normal import tbo_pkg::*; (
    input  logic                  aclk,
    input  stage_en_t             en,
    input  logic signed [VW-1:0]  v0    [3],
    input  logic signed [EW-1:0]  e0    [3],
    input  logic signed [EW-1:0]  e13   [3],
    input  logic signed [WW-1:0]  w_in  [3],
    output logic                  sep_reg
);

    logic signed [2*EW-1:0]  pa_reg  [3];
    logic signed [2*EW-1:0]  pb_reg  [3];
    logic signed [VW-1:0]    v2_reg  [3];
    logic signed [WW-1:0]    w2_reg  [3];
    logic signed [NW-1:0]    n_reg   [3];
    logic signed [NW-1:0]    an_reg  [3];
    logic signed [VW-1:0]    v3_reg  [3];
    logic signed [WW-1:0]    w3_reg  [3];
    logic signed [VW+EW:0]   ppl_reg [3];
    logic signed [VW+EW:0]   pph_reg [3];
    logic signed [WW+EW:0]   rl_reg  [3];
    logic signed [WW+EW:0]   rh_reg  [3];
    logic signed [NW-1:0]    n_next  [3];
    logic signed [SW-1:0]    p_sum;
    logic signed [SW-1:0]    r_sum;
    logic signed [SW-1:0]    p_mag;

    always_ff @(posedge aclk) begin
        if (en.s2) begin
            for (int k = 0; k < 3; k++) begin
                pa_reg[k] <= mul_ee(e0[(k + 1) % 3], e13[(k + 2) % 3]);
                pb_reg[k] <= mul_ee(e0[(k + 2) % 3], e13[(k + 1) % 3]);
                v2_reg[k] <= v0[k];
                w2_reg[k] <= w_in[k];
            end
        end
    end

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_next[k] = NW'(pa_reg[k]) - NW'(pb_reg[k]);
        end
    end

    always_ff @(posedge aclk) begin
        if (en.s3) begin
            for (int k = 0; k < 3; k++) begin
                n_reg[k]  <= n_next[k];
                an_reg[k] <= n_next[k][NW-1] ? -n_next[k] : n_next[k];
                v3_reg[k] <= v2_reg[k];
                w3_reg[k] <= w2_reg[k];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en.s4) begin
            for (int k = 0; k < 3; k++) begin
                ppl_reg[k] <= mul_v20(v3_reg[k], {1'b0, n_reg[k][NS-1:0]});
                pph_reg[k] <= mul_v20(v3_reg[k], n_reg[k][NW-1:NS]);
                rl_reg[k]  <= mul_w20(w3_reg[k], {1'b0, an_reg[k][NS-1:0]});
                rh_reg[k]  <= mul_w20(w3_reg[k], {1'b0, an_reg[k][NW-2:NS]});
            end
        end
    end

    always_comb begin
        p_sum = '0;
        r_sum = '0;
        for (int k = 0; k < 3; k++) begin
            p_sum = p_sum + (SW'(pph_reg[k]) <<< NS) + SW'(ppl_reg[k]);
            r_sum = r_sum + (SW'(rh_reg[k]) <<< NS) + SW'(rl_reg[k]);
        end
        p_mag = p_sum[SW-1] ? -p_sum : p_sum;
    end

    always_ff @(posedge aclk) begin
        if (en.s5) begin
            sep_reg <= p_mag > r_sum;
        end
    end

endmodule

// ===== test/tb.sv =====
// testbench for the triangle against box overlap core
module tb;
    import tbo_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int N_RANDOM = 900;
    localparam logic [AW-1:0] REG_NONE = 3'd6;
    localparam logic [AW-1:0] REG_LAST = 3'd7;

    typedef struct {
        logic signed [CW-1:0] v[9];
        int                   want;
    } tri_row_t;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_valid;
    logic                 s_ready;
    logic signed [CW-1:0] s_a_x, s_a_y, s_a_z, s_b_x, s_b_y, s_b_z, s_c_x, s_c_y, s_c_z;
    logic                 m_valid;
    logic                 m_ready;
    logic                 m_overlaps;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [AW-1:0]        cfg_addr;
    logic [CW-1:0]        cfg_data;

    longint box_q[6];
    logic   overlap_q[$];
    int     fails;
    int     send_idle;
    int     recv_idle;

    triangle_box_overlap_test_core dut (.*);

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    initial begin
        #50ms;
        $display("** triangle_box_overlap_test_core: FAILED **");
        $finish;
    end

    function automatic longint mag(longint x);
        return x < 0 ? -x : x;
    endfunction

    function automatic logic axis_clear(longint ax[3], longint vt[3][3], longint w[3]);
        longint p[3];
        longint hi, lo, m, r;
        for (int i = 0; i < 3; i++)
            p[i] = vt[i][0] * ax[0] + vt[i][1] * ax[1] + vt[i][2] * ax[2];
        hi = p[0];
        lo = p[0];
        for (int i = 1; i < 3; i++) begin
            if (p[i] > hi) hi = p[i];
            if (p[i] < lo) lo = p[i];
        end
        r = w[0] * mag(ax[0]) + w[1] * mag(ax[1]) + w[2] * mag(ax[2]);
        m = (-hi > lo) ? -hi : lo;
        return m > r;
    endfunction

    function automatic logic predict_overlap(logic signed [CW-1:0] v[9]);
        longint vt[3][3], w[3], ed[3][3], ax[3], e2[3];
        logic   sep;
        sep = 1'b0;
        for (int j = 0; j < 3; j++) begin
            w[j] = box_q[3 + j] - box_q[j];
            for (int i = 0; i < 3; i++)
                vt[i][j] = 2 * longint'(v[i * 3 + j]) - (box_q[j] + box_q[3 + j]);
        end
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
                ed[i][j] = vt[(i + 1) % 3][j] - vt[i][j];
        for (int i = 0; i < 3; i++)
            for (int k = 0; k < 3; k++) begin
                // unit axis k crossed with edge i
                ax[k] = 0;
                ax[(k + 1) % 3] = -ed[i][(k + 2) % 3];
                ax[(k + 2) % 3] = ed[i][(k + 1) % 3];
                if (!sep) sep = axis_clear(ax, vt, w);
            end
        for (int k = 0; k < 3; k++) begin
            ax = '{0, 0, 0};
            ax[k] = 1;
            if (!sep) sep = axis_clear(ax, vt, w);
        end
        for (int j = 0; j < 3; j++)
            e2[j] = vt[2][j] - vt[0][j];
        ax[0] = ed[0][1] * e2[2] - ed[0][2] * e2[1];
        ax[1] = ed[0][2] * e2[0] - ed[0][0] * e2[2];
        ax[2] = ed[0][0] * e2[1] - ed[0][1] * e2[0];
        if (!sep) sep = axis_clear(ax, vt, w);
        return !sep;
    endfunction

    task automatic write_box(logic [AW-1:0] idx, logic [CW-1:0] val);
        cfg_valid <= 1'b1;
        cfg_addr  <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        if (idx < 6) box_q[idx] = longint'(signed'(val));
    endtask

    task automatic set_box(int x0, int y0, int z0, int x1, int y1, int z1);
        write_box(REG_MIN_X, x0[CW-1:0]);
        write_box(REG_MIN_Y, y0[CW-1:0]);
        write_box(REG_MIN_Z, z0[CW-1:0]);
        write_box(REG_MAX_X, x1[CW-1:0]);
        write_box(REG_MAX_Y, y1[CW-1:0]);
        write_box(REG_MAX_Z, z1[CW-1:0]);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (overlap_q.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic send_tri(logic signed [CW-1:0] v[9], int want);
        logic p;
        cfg_valid <= 1'b0;
        while ($urandom_range(99) < send_idle) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        p = predict_overlap(v);
        if (want >= 0 && p !== want[0])
            $display("%0t: table entry disagrees, expected %0d predicted %0d",
                     $time, want, p);
        s_valid <= 1'b1;
        {s_a_x, s_a_y, s_a_z} <= {v[0], v[1], v[2]};
        {s_b_x, s_b_y, s_b_z} <= {v[3], v[4], v[5]};
        {s_c_x, s_c_y, s_c_z} <= {v[6], v[7], v[8]};
        do @(posedge aclk); while (!s_ready);
        overlap_q.push_back(want >= 0 ? want[0] : p);
    endtask

    function automatic logic signed [CW-1:0] rnd_coord(int span);
        if (span == 0) return CW'($urandom);
        return CW'(int'($urandom_range(2 * span)) - span);
    endfunction

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (overlap_q.size() == 0) begin
                $display("%0t: unexpected result, expected none actual %0b", $time, m_overlaps);
                fails++;
            end else begin
                if (m_overlaps !== overlap_q[0]) begin
                    $display("%0t: overlaps mismatch, expected %0b actual %0b",
                             $time, overlap_q[0], m_overlaps);
                    fails++;
                end
                void'(overlap_q.pop_front());
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) m_ready <= 1'b0;
        else m_ready <= ($urandom_range(99) >= recv_idle);
    end

    initial begin
        tri_row_t rows[$];
        tri_row_t r;
        int       span;
        int       box[6];
        fails = 0;
        send_idle = 29;
        recv_idle = 47;
        aresetn = 1'b0;
        s_valid = 1'b0;
        cfg_valid = 1'b0;
        cfg_addr = '0;
        cfg_data = '0;
        {s_a_x, s_a_y, s_a_z, s_b_x, s_b_y, s_b_z, s_c_x, s_c_y, s_c_z} = '0;
        box_q = '{0, 0, 0, 0, 0, 0};
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // point box at origin after reset
        rows.push_back('{'{0, 0, 0, 0, 0, 0, 0, 0, 0}, 1});
        rows.push_back('{'{1, 1, 1, 1, 1, 1, 1, 1, 1}, 0});
        rows.push_back('{'{-32768, -32768, -32768, 32767, 32767, 32767,
                           -32768, 32767, 0}, -1});
        rows.push_back('{'{32767, 32767, 32767, 32767, 32767, 32767,
                           32767, 32767, 32767}, 0});
        foreach (rows[i]) send_tri(rows[i].v, rows[i].want);
        drain();

        // unit-ish box, touching and degenerate cases
        rows.delete();
        set_box(-10, -10, -10, 10, 10, 10);
        rows.push_back('{'{10, 0, 0, 20, 0, 0, 20, 5, 0}, 1});
        rows.push_back('{'{11, 0, 0, 20, 0, 0, 20, 5, 0}, 0});
        rows.push_back('{'{-5, -5, 0, 5, 5, 0, 0, 0, 0}, 1});
        rows.push_back('{'{3, 3, 3, 3, 3, 3, 3, 3, 3}, 1});
        rows.push_back('{'{30, 30, 30, 30, 30, 30, 30, 30, 30}, 0});
        rows.push_back('{'{-100, 0, 0, 100, 0, 0, 100, 0, 0}, 1});
        rows.push_back('{'{-100, -100, 15, 100, -100, 15, 0, 100, 15}, 0});
        rows.push_back('{'{-100, -100, 10, 100, -100, 10, 0, 100, 10}, 1});
        rows.push_back('{'{-32768, -32768, 0, 32767, -32768, 0, 0, 32767, 0}, 1});
        rows.push_back('{'{20, 20, -30, 30, 20, 30, 20, 30, 0}, -1});
        rows.push_back('{'{12, 12, 0, 30, 0, 0, 0, 30, 0}, -1});
        rows.push_back('{'{-32768, 32767, -32768, 32767, -32768, 32767,
                           -1, 0, -1}, -1});
        foreach (rows[i]) send_tri(rows[i].v, rows[i].want);
        drain();

        // inverted box and extreme corners
        rows.delete();
        set_box(10, -5, -5, -10, 5, 5);
        rows.push_back('{'{0, 0, 0, 0, 0, 0, 0, 0, 0}, 0});
        rows.push_back('{'{-50, 0, 0, 50, 0, 0, 50, 1, 0}, -1});
        foreach (rows[i]) send_tri(rows[i].v, rows[i].want);
        drain();
        set_box(-32768, -32768, -32768, 32767, 32767, 32767);
        write_box(REG_NONE, 16'h1234);
        write_box(REG_LAST, 16'h8000);
        rows.delete();
        rows.push_back('{'{-32768, -32768, -32768, -32768, -32768, -32768,
                           -32768, -32768, -32768}, 1});
        rows.push_back('{'{32767, -32768, 32767, -32768, 32767, -32768,
                           0, 0, 0}, 1});
        foreach (rows[i]) send_tri(rows[i].v, rows[i].want);
        drain();

        for (int n = 0; n < N_RANDOM; n++) begin
            if (n == N_RANDOM / 3) begin
                send_idle = 47;
                recv_idle = 29;
            end else if (n == 2 * N_RANDOM / 3) begin
                send_idle = 0;
                recv_idle = 0;
            end
            if (n % 100 == 0) begin
                drain();
                span = (n % 300 == 0) ? 0 : 200;
                foreach (box[k]) box[k] = int'(signed'(rnd_coord(span)));
                // keep most boxes ordered, a few inverted
                if ($urandom_range(4) != 0)
                    for (int k = 0; k < 3; k++)
                        if (box[k] > box[k + 3]) {box[k], box[k + 3]} = {box[k + 3], box[k]};
                set_box(box[0], box[1], box[2], box[3], box[4], box[5]);
            end
            span = ($urandom_range(3) == 0) ? 0 : 300;
            for (int k = 0; k < 9; k++) r.v[k] = rnd_coord(span);
            if ($urandom_range(7) == 0)
                for (int k = 0; k < 3; k++) r.v[6 + k] = r.v[k];
            send_tri(r.v, -1);
        end

        drain();
        if (fails == 0 && overlap_q.size() == 0)
            $display("** triangle_box_overlap_test_core: PASSED **");
        else
            $display("** triangle_box_overlap_test_core: FAILED **");
        $finish;
    end
endmodule
